### hdl/bstr_pkg.sv
// Shared types, codes and defaults of the scan table and roam select block.
// No dependencies; hdl/ files other than bstr_ifs refer to it by scoped names.
`default_nettype none

package bstr_pkg;

  // Default sizes, overridable on the top level
  localparam int ENTRIES_DEF    = 32;
  localparam int SSID_BYTES_DEF = 32;

  // Width of the occupancy count reported with each result
  localparam int COUNT_W = 6;

  // Reset values of the roam registers
  localparam logic signed [7:0] FLOOR_RST = -8'sd75;
  localparam logic [6:0]        HYST_RST  = 7'd10;

  // Configuration register indexes
  localparam logic CFG_FLOOR = 1'b0;
  localparam logic CFG_HYST  = 1'b1;

  // Command codes carried on the final beat
  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_BEST = 2'd1,
    KIND_ROAM = 2'd2,
    KIND_DROP = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAN = 2'd1,
    ST_FULL     = 2'd2,
    ST_NO_MATCH = 2'd3
  } status_t;

  // Command sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_EMIT
  } fsm_t;

  // One table entry apart from its name
  typedef struct packed {
    logic [47:0]       addr;
    logic [7:0]        chan;
    logic signed [7:0] rssi;
    logic              rsn;
  } entry_t;

  // Control from the sequencer to the name stager
  typedef struct packed {
    logic take;   // a beat is accepted this cycle
    logic last;   // it is the final beat
    logic clear;  // drop the staged name
  } stage_ctl_t;

  // Index width for n entries, at least one bit
  function automatic int idx_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

### hdl/bstr_ifs.sv
// Valid/ready channel interfaces for command beats and result words.
// Depends on nothing; used by the top level.
`default_nettype none

interface bstr_cmd_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [47:0]       bssid;
  logic [7:0]        chan;
  logic signed [7:0] rssi;
  logic signed [7:0] other_rssi;
  logic              rsn;
  logic [63:0]       ssid_word;
  logic              ssid_last;

  modport source (
    output valid, kind, bssid, chan, rssi, other_rssi, rsn, ssid_word, ssid_last,
    input  ready
  );
  modport sink (
    input  valid, kind, bssid, chan, rssi, other_rssi, rsn, ssid_word, ssid_last,
    output ready
  );
endinterface

interface bstr_rsp_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [47:0]       found_bssid;
  logic signed [7:0] found_rssi;
  logic              roam;
  logic [5:0]        entry_count;

  modport source (
    output valid, status, found_bssid, found_rssi, roam, entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, found_bssid, found_rssi, roam, entry_count,
    output ready
  );
endinterface

`default_nettype wire

### hdl/bss_scan_table_roam_select_top.sv
// Scan table top level: command sequencer, entry and name RAMs, result register.
// Depends on bstr_pkg, bstr_ifs, bstr_ram and bstr_stage.
`default_nettype none

// A command arrives as one or more beats on cmd; non-final beats are taken one
// per cycle and only stage name bytes. On the final beat the command runs.
// An add with a nonzero channel or a best query walks every table slot through
// the entry and name RAMs, one slot per cycle, and an add then passes a write
// state before its result; a roam query or a rejected channel goes straight to
// the result, and a dropped command (kind 3) gives no result. The result is held
// in an output register until rsp takes it; the next command is accepted once it
// has been loaded. Occupancy bits live in flip-flops cleared by reset, so there
// is no clearing pass; roam_floor and roam_hyst (the roam hysteresis) are written
// through cfg_we; the user must write them only while idle, not enforced here.
module bss_scan_table_roam_select_top #(
  parameter int ENTRIES    = bstr_pkg::ENTRIES_DEF,
  parameter int SSID_BYTES = bstr_pkg::SSID_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  bstr_cmd_if.sink        cmd,
  bstr_rsp_if.source      rsp,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  localparam int SSID_WORDS = (SSID_BYTES + 7) / 8;
  localparam int NAME_W     = 64 * SSID_WORDS;
  localparam int IDX_W      = bstr_pkg::idx_bits(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int ENTRY_W    = $bits(bstr_pkg::entry_t);

  // Sequencer
  bstr_pkg::fsm_t    state, state_next;
  logic              accept;
  logic              issue;
  logic              scan_done;
  logic              mem_we;
  logic              emit_load;
  logic              stage_clr;

  // Command captured on the final beat
  bstr_pkg::kind_t   c_kind;
  logic [47:0]       c_addr;
  logic [7:0]        c_chan;
  logic signed [7:0] c_rssi;
  logic              c_rsn;

  // Scan bookkeeping
  logic [CNT_W-1:0]  cnt;
  logic              cmp_vld;
  logic [IDX_W-1:0]  cmp_idx;
  logic              hit_found;
  logic [IDX_W-1:0]  hit_slot;
  logic              free_found;
  logic [IDX_W-1:0]  free_slot;
  logic [IDX_W-1:0]  wr_slot;

  // Table state outside the RAMs
  logic [ENTRIES-1:0] valid_bits;
  logic [CNT_W-1:0]   used_count;

  // Pending result and output register
  bstr_pkg::status_t res_status;
  logic [47:0]       res_bssid;
  logic signed [7:0] res_rssi;
  logic              res_roam;
  logic              out_valid;
  bstr_pkg::status_t out_status;
  logic [47:0]       out_bssid;
  logic signed [7:0] out_rssi;
  logic              out_roam;
  logic [bstr_pkg::COUNT_W-1:0] out_count;

  // Roam registers
  logic signed [7:0] roam_floor;
  logic [6:0]        roam_hyst;

  // RAM ports and the name path
  logic [ENTRY_W-1:0] ent_rdata;
  bstr_pkg::entry_t   ent_q;
  bstr_pkg::entry_t   ent_wr;
  logic [NAME_W-1:0]  name_rdata;
  logic [NAME_W-1:0]  stage_name;
  logic [NAME_W-1:0]  name_wr;
  bstr_pkg::stage_ctl_t stage_ctl;

  // Roam decision, exact in ten bits
  logic signed [9:0] cur_x, cand_x, lim_x, floor_x;
  logic              roam_cond;

  assign accept = cmd.valid && cmd.ready;

  assign cur_x     = {{2{cmd.rssi[7]}}, cmd.rssi};
  assign cand_x    = {{2{cmd.other_rssi[7]}}, cmd.other_rssi};
  assign floor_x   = {{2{roam_floor[7]}}, roam_floor};
  assign lim_x     = cur_x + $signed({3'b000, roam_hyst});
  assign roam_cond = (cur_x < floor_x) && (cand_x > lim_x);

  assign scan_done = (cnt == CNT_W'(ENTRIES)) && !cmp_vld;
  assign ent_q     = bstr_pkg::entry_t'(ent_rdata);
  assign wr_slot   = hit_found ? hit_slot : free_slot;

  // Stored names keep one byte less than query names
  always_comb begin
    name_wr = stage_name;
    name_wr[(SSID_BYTES-1)*8 +: 8] = 8'd0;
  end

  always_comb begin
    ent_wr.addr = c_addr;
    ent_wr.chan = c_chan;
    ent_wr.rssi = c_rssi;
    ent_wr.rsn  = c_rsn;
  end

  assign stage_ctl.take  = accept;
  assign stage_ctl.last  = cmd.ssid_last;
  assign stage_ctl.clear = stage_clr;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bstr_pkg::S_IDLE: begin
        if (accept && cmd.ssid_last) begin
          priority if (cmd.kind == bstr_pkg::KIND_DROP) begin
            state_next = bstr_pkg::S_IDLE;
          end else if (cmd.kind == bstr_pkg::KIND_BEST ||
                       (cmd.kind == bstr_pkg::KIND_ADD && cmd.chan != 8'd0)) begin
            state_next = bstr_pkg::S_SCAN;
          end else begin
            state_next = bstr_pkg::S_EMIT;
          end
        end
      end
      bstr_pkg::S_SCAN: begin
        if (scan_done) begin
          state_next = (c_kind == bstr_pkg::KIND_ADD) ? bstr_pkg::S_WRITE
                                                      : bstr_pkg::S_EMIT;
        end
      end
      bstr_pkg::S_WRITE: state_next = bstr_pkg::S_EMIT;
      bstr_pkg::S_EMIT: begin
        if (emit_load) begin
          state_next = bstr_pkg::S_IDLE;
        end
      end
      default: state_next = bstr_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    cmd.ready = (state == bstr_pkg::S_IDLE);
    issue     = (state == bstr_pkg::S_SCAN) && (cnt != CNT_W'(ENTRIES));
    mem_we    = (state == bstr_pkg::S_WRITE) && (hit_found || free_found);
    emit_load = (state == bstr_pkg::S_EMIT) && (!out_valid || rsp.ready);
    stage_clr = emit_load ||
                (accept && cmd.ssid_last && cmd.kind == bstr_pkg::KIND_DROP);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bstr_pkg::S_IDLE;
      cnt        <= '0;
      cmp_vld    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      valid_bits <= '0;
      used_count <= '0;
      out_valid  <= 1'b0;
      roam_floor <= bstr_pkg::FLOOR_RST;
      roam_hyst  <= bstr_pkg::HYST_RST;
    end else begin
      state <= state_next;

      // Roam registers
      if (cfg_we) begin
        unique case (cfg_index)
          bstr_pkg::CFG_FLOOR: roam_floor <= cfg_wdata;
          bstr_pkg::CFG_HYST:  roam_hyst  <= cfg_wdata[6:0];
          default: ;
        endcase
      end

      // Start of a scan
      if (accept && cmd.ssid_last) begin
        cnt        <= '0;
        cmp_vld    <= 1'b0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
      end else begin
        cmp_vld <= issue;
        if (issue) begin
          cnt <= cnt + 1'b1;
        end
        // Compare the slot whose read data is back
        if (cmp_vld) begin
          if (c_kind == bstr_pkg::KIND_ADD) begin
            if (valid_bits[cmp_idx] && ent_q.addr == c_addr && !hit_found) begin
              hit_found <= 1'b1;
            end
            if (!valid_bits[cmp_idx] && !free_found) begin
              free_found <= 1'b1;
            end
          end else if (valid_bits[cmp_idx] && name_rdata == stage_name &&
                       (!hit_found || ent_q.rssi > res_rssi)) begin
            hit_found <= 1'b1;
          end
        end
      end

      // Claim a free slot
      if (mem_we && !hit_found) begin
        valid_bits[free_slot] <= 1'b1;
        used_count            <= used_count + 1'b1;
      end

      // Output register
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept && cmd.ssid_last) begin
      c_kind     <= bstr_pkg::kind_t'(cmd.kind);
      c_addr     <= cmd.bssid;
      c_chan     <= cmd.chan;
      c_rssi     <= cmd.rssi;
      c_rsn      <= cmd.rsn;
      res_status <= (cmd.kind == bstr_pkg::KIND_ADD && cmd.chan == 8'd0)
                    ? bstr_pkg::ST_BAD_CHAN : bstr_pkg::ST_OK;
      res_bssid  <= '0;
      res_rssi   <= '0;
      res_roam   <= (cmd.kind == bstr_pkg::KIND_ROAM) && roam_cond;
    end

    if (issue) begin
      cmp_idx <= cnt[IDX_W-1:0];
    end

    // Slot tracking during the scan
    if (state == bstr_pkg::S_SCAN && cmp_vld) begin
      if (c_kind == bstr_pkg::KIND_ADD) begin
        if (valid_bits[cmp_idx] && ent_q.addr == c_addr && !hit_found) begin
          hit_slot <= cmp_idx;
        end
        if (!valid_bits[cmp_idx] && !free_found) begin
          free_slot <= cmp_idx;
        end
      end else if (valid_bits[cmp_idx] && name_rdata == stage_name &&
                   (!hit_found || ent_q.rssi > res_rssi)) begin
        hit_slot  <= cmp_idx;
        res_bssid <= ent_q.addr;
        res_rssi  <= ent_q.rssi;
      end
    end

    if (state == bstr_pkg::S_SCAN && scan_done && c_kind == bstr_pkg::KIND_BEST) begin
      res_status <= hit_found ? bstr_pkg::ST_OK : bstr_pkg::ST_NO_MATCH;
    end

    if (state == bstr_pkg::S_WRITE) begin
      res_status <= (hit_found || free_found) ? bstr_pkg::ST_OK : bstr_pkg::ST_FULL;
    end

    if (emit_load) begin
      out_status <= res_status;
      out_bssid  <= res_bssid;
      out_rssi   <= res_rssi;
      out_roam   <= res_roam;
      out_count  <= bstr_pkg::COUNT_W'(used_count);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.found_bssid = out_bssid;
  assign rsp.found_rssi  = out_rssi;
  assign rsp.roam        = out_roam;
  assign rsp.entry_count = out_count;

  // Name stager
  bstr_stage #(
    .SSID_BYTES (SSID_BYTES)
  ) u_stage (
    .clk  (clk),
    .rst  (rst),
    .ctl  (stage_ctl),
    .word (cmd.ssid_word),
    .name (stage_name)
  );

  // Address, channel, signal and security per slot
  bstr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_slot),
    .wdata (ENTRY_W'(ent_wr)),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (ent_rdata)
  );

  // Network name per slot, all words side by side
  bstr_ram #(
    .WIDTH (NAME_W),
    .DEPTH (ENTRIES)
  ) u_name_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_slot),
    .wdata (name_wr),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (name_rdata)
  );

endmodule

`default_nettype wire

### hdl/bstr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on bstr_pkg for the address width helper.
`default_nettype none

module bstr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [bstr_pkg::idx_bits(DEPTH)-1:0]     waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [bstr_pkg::idx_bits(DEPTH)-1:0]     raddr,
  output      logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/bstr_stage.sv
// Name stager: collects up to (SSID_BYTES+7)/8 8-byte beats (four by default),
// zeroes bytes after the first zero and past SSID_BYTES. Depends on bstr_pkg.
`default_nettype none

module bstr_stage #(
  parameter int SSID_BYTES = bstr_pkg::SSID_BYTES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire bstr_pkg::stage_ctl_t         ctl,
  input  wire logic [63:0]                  word,
  output      logic [64*((SSID_BYTES+7)/8)-1:0] name
);

  localparam int WORDS = (SSID_BYTES + 7) / 8;
  localparam int WI    = bstr_pkg::idx_bits(WORDS);
  localparam int BI    = $clog2(WORDS + 1);

  logic [63:0]   stage [WORDS];
  logic [BI-1:0] beat_index;
  logic          ended;
  logic          ended_next;
  logic          beat_ok;
  logic [63:0]   masked;

  assign beat_ok = (beat_index < BI'(WORDS));

  // Byte mask: keep bytes before the first zero and inside the name limit
  always_comb begin
    logic zseen;
    logic [7:0] b;
    zseen  = ended;
    masked = '0;
    for (int j = 0; j < 8; j++) begin
      b = word[8*j +: 8];
      if (b == 8'd0) begin
        zseen = 1'b1;
      end
      if (!zseen && ((int'(beat_index) * 8 + j) < SSID_BYTES)) begin
        masked[8*j +: 8] = b;
      end
    end
    ended_next = zseen;
  end

  // Stage words and beat position
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_index <= '0;
      ended      <= 1'b0;
      for (int w = 0; w < WORDS; w++) begin
        stage[w] <= '0;
      end
    end else begin
      if (ctl.clear) begin
        for (int w = 0; w < WORDS; w++) begin
          stage[w] <= '0;
        end
      end else if (ctl.take && beat_ok) begin
        stage[beat_index[WI-1:0]] <= masked;
      end
      if (ctl.take) begin
        if (ctl.last) begin
          beat_index <= '0;
          ended      <= 1'b0;
        end else if (beat_ok) begin
          beat_index <= beat_index + 1'b1;
          ended      <= ended_next;
        end
      end
    end
  end

  // Flatten, first word in the low bits
  always_comb begin
    for (int w = 0; w < WORDS; w++) begin
      name[64*w +: 64] = stage[w];
    end
  end

endmodule

`default_nettype wire

### hdl/bstr_checker.sv
// Port-level checks of the scan table top level, bound to it below.
// Depends on bstr_pkg and bss_scan_table_roam_select_top.
`default_nettype none

module bstr_checker #(
  parameter int ENTRIES = bstr_pkg::ENTRIES_DEF
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [1:0]  rsp_status,
  input wire logic [47:0] rsp_found_bssid,
  input wire logic [7:0]  rsp_found_rssi,
  input wire logic        rsp_roam,
  input wire logic [5:0]  rsp_entry_count
);

  // A stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
    $stable(rsp_found_bssid) && $stable(rsp_found_rssi) &&
    $stable(rsp_roam) && $stable(rsp_entry_count))
    else $error("result word changed while stalled");

  // No result right after reset
  a_rst_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // Occupancy never exceeds the table size, checked for tables under 64 entries
  a_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (ENTRIES >= 64) || (int'(rsp_entry_count) <= ENTRIES))
    else $error("entry count beyond table size");

  // Failed commands and roam advice carry no found entry
  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != bstr_pkg::ST_OK || rsp_roam) |->
    rsp_found_bssid == 48'd0 && rsp_found_rssi == 8'd0)
    else $error("found fields set on a result without a match");

endmodule

bind bss_scan_table_roam_select_top bstr_checker #(
  .ENTRIES (ENTRIES)
) u_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_found_bssid (rsp.found_bssid),
  .rsp_found_rssi  (rsp.found_rssi),
  .rsp_roam        (rsp.roam),
  .rsp_entry_count (rsp.entry_count)
);

`default_nettype wire
